@@ sv/lpr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the length-prefixed packet ring.
// No dependencies; every other file of the block imports this package.
package lpr_pkg;

  // Ring geometry. RING_BYTES must be a power of two, so that positions wrap
  // by plain overflow of a PTR_W-bit counter.
  localparam int RING_BYTES = 1024;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int HDR_BYTES  = 4;
  localparam int RESULT_CAP = 64;

  // Widths of the item fields
  localparam int OPC_W   = 2;
  localparam int PLEN_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int LEN_W   = 7;   // payload length after the limit check

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [OPC_W-1:0] {
    OP_SEND_BEGIN = 2'd0,
    OP_SEND_BYTE  = 2'd1,
    OP_RECV       = 2'd2,
    OP_REWIND     = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CORRUPT  = 3'd4,
    ST_NO_BEGIN = 3'd5
  } status_e;

  // Command class decided at the front
  typedef enum logic [2:0] {
    CMD_BEGIN,
    CMD_BAD_LEN,
    CMD_BYTE,
    CMD_RECV,
    CMD_REWIND
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

endpackage

@@ sv/lpr_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command beats, checks send lengths, queues commands.
// Depends on lpr_pkg.
module lpr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lpr_pkg::OPC_W-1:0]  opcode_i,
  input  logic [lpr_pkg::PLEN_W-1:0] packet_length_i,
  input  logic [lpr_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [lpr_pkg::LEN_W-1:0]  limit_i,
  input  logic                       pop_i,
  output logic                       cmd_valid_o,
  output lpr_pkg::cmd_t              cmd_o
);
  import lpr_pkg::*;

  cmd_t              cmd_in;
  cmd_t              cmd_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, full;

  // Classify the incoming beat
  always_comb begin
    cmd_in.len  = packet_length_i[LEN_W-1:0];
    cmd_in.data = data_byte_i;
    case (opcode_e'(opcode_i))
      OP_SEND_BEGIN: begin
        if (packet_length_i == '0 ||
            packet_length_i > PLEN_W'(limit_i)) begin
          cmd_in.kind = CMD_BAD_LEN;
        end else begin
          cmd_in.kind = CMD_BEGIN;
        end
      end
      OP_SEND_BYTE: cmd_in.kind = CMD_BYTE;
      OP_RECV:      cmd_in.kind = CMD_RECV;
      OP_REWIND:    cmd_in.kind = CMD_REWIND;
      default:      cmd_in.kind = CMD_REWIND;
    endcase
  end

  assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign busy  = full;
  assign push  = start && !full;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];

endmodule

@@ sv/lpr_back.sv @@
`timescale 1ns / 1ps
// Back end: ring memory, pointers and the sequencer that runs each command.
// Depends on lpr_pkg.
module lpr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  lpr_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  input  logic [lpr_pkg::LEN_W-1:0]  limit_i,
  output logic                       valid_o,
  output logic [lpr_pkg::STAT_W-1:0] status_o,
  output logic [lpr_pkg::BYTE_W-1:0] read_byte_o,
  output logic                       last_o
);
  import lpr_pkg::*;

  localparam int CNT_W = $clog2(HDR_BYTES + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR_WR,
    B_HDR_RD,
    B_STREAM
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PTR_W-1:0]   cwp_q, cwp_d, swp_q, swp_d, rp_q, rp_d, nrp_q, nrp_d;
  logic [PTR_W-1:0]   p_q, p_d, used_q, used_d;
  logic [LEN_W-1:0]   bts_q, bts_d, iss_q, iss_d, rem_q, rem_d;
  logic [BYTE_W-1:0]  len_q, len_d;
  logic               hi_nz_q, hi_nz_d, pend_q, pend_d;
  logic               valid_q, valid_d, last_q, last_d;
  status_e            status_q, status_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;

  logic [BYTE_W-1:0]  ring_mem [RING_BYTES];
  logic [BYTE_W-1:0]  rdata_q;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_addr;
  logic [BYTE_W-1:0]  mem_wdata;

  logic [PTR_W-1:0]   used_snd, used_rcv;
  logic [PTR_W:0]     space_sum;
  logic               hdr_bad;

  // Occupancy as seen by a send and by a receive
  assign used_snd  = cwp_q - rp_q;
  assign used_rcv  = cwp_q - nrp_q;
  assign space_sum = (PTR_W+1)'(used_snd) + (PTR_W+1)'(cmd_i.len)
                   + (PTR_W+1)'(HDR_BYTES);

  // Header check once the last header byte is back from memory
  assign hdr_bad = hi_nz_q || (rdata_q != '0) || (len_q == '0) ||
                   (len_q > BYTE_W'(limit_i)) ||
                   ((PTR_W+1)'(len_q) + (PTR_W+1)'(HDR_BYTES) > (PTR_W+1)'(used_q));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cwp_d     = cwp_q;
    swp_d     = swp_q;
    rp_d      = rp_q;
    nrp_d     = nrp_q;
    p_d       = p_q;
    used_d    = used_q;
    bts_d     = bts_q;
    iss_d     = iss_q;
    rem_d     = rem_q;
    len_d     = len_q;
    hi_nz_d   = hi_nz_q;
    pend_d    = pend_q;
    valid_d   = 1'b0;
    status_d  = ST_OK;
    byte_d    = '0;
    last_d    = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = p_q;
    mem_wdata = cmd_i.data;
    pop_o     = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_BAD_LEN: begin
              valid_d  = 1'b1;
              status_d = ST_BAD_LEN;
            end
            CMD_BEGIN: begin
              if (space_sum >= (PTR_W+1)'(RING_BYTES)) begin
                valid_d  = 1'b1;
                status_d = ST_NO_SPACE;
              end else begin
                len_d   = BYTE_W'(cmd_i.len);
                p_d     = cwp_q;
                cnt_d   = '0;
                state_d = B_HDR_WR;
              end
            end
            CMD_BYTE: begin
              valid_d = 1'b1;
              if (bts_q == '0) begin
                status_d = ST_NO_BEGIN;
              end else begin
                mem_we   = 1'b1;
                mem_addr = swp_q;
                swp_d    = swp_q + 1'b1;
                bts_d    = bts_q - 1'b1;
                // last payload byte publishes the packet
                if (bts_q == LEN_W'(1)) begin
                  cwp_d = swp_q + 1'b1;
                end
              end
            end
            CMD_RECV: begin
              // free the packet read before
              rp_d = nrp_q;
              if (used_rcv == '0) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else if (used_rcv <= PTR_W'(HDR_BYTES)) begin
                valid_d  = 1'b1;
                status_d = ST_CORRUPT;
              end else begin
                used_d  = used_rcv;
                p_d     = nrp_q;
                cnt_d   = '0;
                hi_nz_d = 1'b0;
                state_d = B_HDR_RD;
              end
            end
            CMD_REWIND: begin
              cwp_d   = '0;
              swp_d   = '0;
              rp_d    = '0;
              nrp_d   = '0;
              bts_d   = '0;
              valid_d = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      // Header bytes: length low byte, then zeros (length fits one byte)
      B_HDR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt_q == '0) ? len_q : '0;
        p_d       = p_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HDR_BYTES - 1)) begin
          swp_d   = p_q + 1'b1;
          bts_d   = len_q[LEN_W-1:0];
          valid_d = 1'b1;
          state_d = B_IDLE;
        end
      end

      // Read header: each address goes out ahead of its data, which the memory registers
      B_HDR_RD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q < CNT_W'(HDR_BYTES)) begin
          p_d = p_q + 1'b1;
        end
        if (cnt_q == CNT_W'(1)) begin
          len_d = rdata_q;
        end else if (cnt_q > CNT_W'(1) && cnt_q < CNT_W'(HDR_BYTES)) begin
          hi_nz_d = hi_nz_q || (rdata_q != '0);
        end
        if (cnt_q == CNT_W'(HDR_BYTES)) begin
          if (hdr_bad) begin
            valid_d  = 1'b1;
            status_d = ST_CORRUPT;
            state_d  = B_IDLE;
          end else begin
            iss_d   = len_q[LEN_W-1:0];
            rem_d   = len_q[LEN_W-1:0];
            pend_d  = 1'b0;
            state_d = B_STREAM;
          end
        end
      end

      // Payload: issue reads while any remain, emit each returned byte
      B_STREAM: begin
        pend_d = (iss_q != '0);
        if (iss_q != '0) begin
          p_d   = p_q + 1'b1;
          iss_d = iss_q - 1'b1;
        end
        if (pend_q) begin
          valid_d = 1'b1;
          byte_d  = rdata_q;
          last_d  = (rem_q == LEN_W'(1));
          rem_d   = rem_q - 1'b1;
          if (rem_q == LEN_W'(1)) begin
            nrp_d   = p_q;
            state_d = B_IDLE;
          end
        end
      end

      default: state_d = B_IDLE;
    endcase
  end

  // Sequencer state, pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      cwp_q    <= '0;
      swp_q    <= '0;
      rp_q     <= '0;
      nrp_q    <= '0;
      p_q      <= '0;
      used_q   <= '0;
      bts_q    <= '0;
      iss_q    <= '0;
      rem_q    <= '0;
      hi_nz_q  <= 1'b0;
      pend_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cwp_q    <= cwp_d;
      swp_q    <= swp_d;
      rp_q     <= rp_d;
      nrp_q    <= nrp_d;
      p_q      <= p_d;
      used_q   <= used_d;
      bts_q    <= bts_d;
      iss_q    <= iss_d;
      rem_q    <= rem_d;
      hi_nz_q  <= hi_nz_d;
      pend_q   <= pend_d;
      valid_q  <= valid_d;
    end
  end

  // Result payload and header length
  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    status_q <= status_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
  end

  // Single-port ring memory with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= ring_mem[mem_addr];
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign read_byte_o = byte_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // No send in progress means nothing is staged beyond the published end
  a_idle_staging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bts_q == '0) |-> (cwp_q == swp_q))
    else $error("staging pointer apart from committed pointer with no send open");

  // A failing result always closes its command
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != ST_OK) |-> last_q)
    else $error("error result without last");

  // Streaming always has bytes left to deliver
  a_stream_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_STREAM) |-> (rem_q != '0))
    else $error("stream state with no bytes left");

  // The final payload beat returns the sequencer to idle
  a_stream_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_STREAM && pend_q && rem_q == LEN_W'(1)) |=>
      (state_q == B_IDLE && valid_q && last_q))
    else $error("stream did not end after last byte");

  // Commands leave the queue only while idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == B_IDLE && cmd_valid_i))
    else $error("queue popped outside idle");
`endif

endmodule

@@ sv/length_prefixed_packet_ring_unit.sv @@
`timescale 1ns / 1ps
// Top level of the length-prefixed packet ring: APB limit register,
// command front end and ring back end. Depends on lpr_pkg, lpr_front, lpr_back.
//
// Commands are taken when start is high and busy is low; a two-entry queue
// sits in front of the sequencer, so busy rises only when two commands wait.
// Results come out one per cycle on valid_o and cannot be held off. The
// sequencer runs one command at a time on the single-port ring memory: a
// send byte, rewind, rejected send or early receive failure is settled in
// the idle state; a send begin also makes four header writes; a receive
// fetches and checks the header, then streams len payload bytes. Each
// result is registered, and each command passes through the queue before
// the sequencer sees it. The ring needs no clearing after reset.
module length_prefixed_packet_ring_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command port
  input  logic                       start,
  output logic                       busy,
  input  logic [lpr_pkg::OPC_W-1:0]  opcode_i,
  input  logic [lpr_pkg::PLEN_W-1:0] packet_length_i,
  input  logic [lpr_pkg::BYTE_W-1:0] data_byte_i,
  // results
  output logic                       valid_o,
  output logic [lpr_pkg::STAT_W-1:0] status_o,
  output logic [lpr_pkg::BYTE_W-1:0] read_byte_o,
  output logic                       last_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lpr_pkg::*;

  localparam logic [1:0] ADDR_MAX_PKT = 2'd0;

  logic [LEN_W-1:0] max_q;
  logic [LEN_W-1:0] limit;
  logic             pop;
  logic             cmd_valid;
  cmd_t             cmd;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LEN_W'(RESULT_CAP);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_PKT) begin
      max_q <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_PKT) ? 32'(max_q) : '0;

  // Effective limit: a receive can return at most RESULT_CAP beats
  assign limit = (max_q > LEN_W'(RESULT_CAP)) ? LEN_W'(RESULT_CAP) : max_q;

  lpr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .packet_length_i (packet_length_i),
    .data_byte_i     (data_byte_i),
    .limit_i         (limit),
    .pop_i           (pop),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  lpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .limit_i     (limit),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .read_byte_o (read_byte_o),
    .last_o      (last_o)
  );

endmodule
